@@ hdl/sunrise_window_wake_timer_top_defines.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef SUNRISE_WINDOW_WAKE_TIMER_TOP_DEFINES_SVH
`define SUNRISE_WINDOW_WAKE_TIMER_TOP_DEFINES_SVH

// Property must hold at every rising edge outside reset.
`define SWWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swwt assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define SWWT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("swwt forbidden condition seen");

`endif

@@ hdl/swwt_pkg.sv @@
package swwt_pkg;

  localparam int unsigned MinW      = 11;  // minute of day, also up to 31*60+63
  localparam int unsigned SecW      = 17;  // second of day as given
  localparam int unsigned DeltaW    = 7;   // month-to-month change in minutes
  localparam int unsigned NumW      = 5;   // clamped day offset and month length
  localparam int unsigned DivW      = 6;   // twice the month length
  localparam int unsigned XW        = 13;  // biased interpolation numerator
  localparam int unsigned RecW      = 11;  // reciprocal of twice the month length
  localparam int unsigned RecShift  = 16;
  localparam int unsigned QW        = 7;   // biased quotient
  localparam int unsigned NumStages = 6;

  // Bias keeps the numerator positive: floor(y + RoundBias) = floor(y) + RoundBias.
  localparam int unsigned RoundBias = 64;
  localparam int unsigned DayOffset = 2 * RoundBias + 1;

  localparam logic [10:0] Recip60       = 11'd1093;  // exact floor(m/60) for m < 1475
  localparam logic [17:0] SecondsPerDay = 18'd86400;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } in_item_t;

  typedef struct packed {
    logic [4:0]      rise_hour;
    logic [5:0]      rise_minute;
    logic [4:0]      set_hour;
    logic [5:0]      set_minute;
    logic            is_daytime;
    logic [SecW-1:0] seconds_to_sunrise;
  } out_item_t;

  typedef struct packed {
    logic [4:0] rise_h;
    logic [5:0] rise_m;
    logic [4:0] set_h;
    logic [5:0] set_m;
  } rom_entry_t;

  // Load enables of the interpolation stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_adv_t;

  // Month-start sunrise and sunset, January again at the end.
  function automatic rom_entry_t sun_rom(input logic [3:0] idx);
    rom_entry_t e;
    case (idx)
      4'd0:    e = '{5'd6, 6'd41, 5'd18, 6'd5};
      4'd1:    e = '{5'd6, 6'd47, 5'd18, 6'd22};
      4'd2:    e = '{5'd6, 6'd40, 5'd18, 6'd28};
      4'd3:    e = '{5'd6, 6'd20, 5'd18, 6'd28};
      4'd4:    e = '{5'd6, 6'd3,  5'd18, 6'd33};
      4'd5:    e = '{5'd5, 6'd54, 5'd18, 6'd42};
      4'd6:    e = '{5'd5, 6'd55, 5'd18, 6'd47};
      4'd7:    e = '{5'd6, 6'd3,  5'd18, 6'd43};
      4'd8:    e = '{5'd6, 6'd7,  5'd18, 6'd25};
      4'd9:    e = '{5'd6, 6'd5,  5'd18, 6'd3};
      4'd10:   e = '{5'd6, 6'd9,  5'd17, 6'd44};
      4'd11:   e = '{5'd6, 6'd22, 5'd17, 6'd41};
      default: e = '{5'd6, 6'd41, 5'd18, 6'd5};
    endcase
    return e;
  endfunction

  function automatic logic [NumW-1:0] month_len(input logic [3:0] idx);
    logic [NumW-1:0] len;
    case (idx)
      4'd1:                     len = NumW'(28);
      4'd3, 4'd5, 4'd8, 4'd10:  len = NumW'(30);
      default:                  len = NumW'(31);
    endcase
    return len;
  endfunction

  // floor(2^RecShift / (2*len)); one correction step finishes the quotient.
  function automatic logic [RecW-1:0] recip_2d(input logic [NumW-1:0] len);
    logic [RecW-1:0] rec;
    case (len)
      NumW'(28): rec = RecW'(1170);
      NumW'(30): rec = RecW'(1092);
      default:   rec = RecW'(1057);
    endcase
    return rec;
  endfunction

  function automatic logic [MinW-1:0] to_minutes(input logic [4:0] h, input logic [5:0] m);
    return MinW'({h, 6'b0}) - MinW'({h, 2'b0}) + MinW'(m);
  endfunction

endpackage

@@ hdl/sunrise_window_wake_timer_top.sv @@
// Sunrise window and wake timer: for each date and time of day it returns the
// interpolated sunrise and sunset, a daytime flag and the seconds left to the next
// sunrise. Six-stage pipeline: an item enters every cycle unless a stalled output
// has filled the pipeline; it passes the ROM lookup, the reciprocal divide (numerator, multiply, correct)
// and the split into hours and minutes. Valid bits travel with each stage, a
// stage fills whenever it is empty or its contents move on, so bubbles close up
// under a stalled output. No state is kept between items.
`include "sunrise_window_wake_timer_top_defines.svh"

module sunrise_window_wake_timer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swwt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swwt_pkg::out_item_t out_item_o
);

  localparam int unsigned NS   = swwt_pkg::NumStages;
  localparam int unsigned MinW = swwt_pkg::MinW;
  localparam int unsigned SecW = swwt_pkg::SecW;
  localparam int unsigned MulW = 2 * MinW;

  // Pipeline control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o = adv[0];

  // Stage 1: month select, ROM lookup, clamp
  logic [3:0]                          cur, nxt;
  logic [swwt_pkg::NumW-1:0]           dlen, num;
  logic [MinW-1:0]                     ra, rb, sa, sb;
  swwt_pkg::rom_entry_t                e_cur, e_nxt;

  logic [swwt_pkg::NumW-1:0]           num_q, dlen_q;
  logic [MinW-1:0]                     ra_q, sa_q;
  logic signed [swwt_pkg::DeltaW-1:0]  rd_q, sd_q;
  logic [MinW-1:0]                     now_min0_q;
  logic [5:0]                          sec0_q;

  always_comb begin
    if (in_item_i.month inside {[4'd1:4'd12]}) begin
      cur = in_item_i.month - 4'd1;
    end else begin
      cur = 4'd0;
    end
    nxt   = cur + 4'd1;
    dlen  = swwt_pkg::month_len(cur);
    num   = (in_item_i.day == '0) ? '0 : in_item_i.day - 5'd1;
    if (num > dlen) num = dlen;
    e_cur = swwt_pkg::sun_rom(cur);
    e_nxt = swwt_pkg::sun_rom(nxt);
    ra    = swwt_pkg::to_minutes(e_cur.rise_h, e_cur.rise_m);
    rb    = swwt_pkg::to_minutes(e_nxt.rise_h, e_nxt.rise_m);
    sa    = swwt_pkg::to_minutes(e_cur.set_h, e_cur.set_m);
    sb    = swwt_pkg::to_minutes(e_nxt.set_h, e_nxt.set_m);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      num_q      <= num;
      dlen_q     <= dlen;
      ra_q       <= ra;
      sa_q       <= sa;
      rd_q       <= swwt_pkg::DeltaW'(rb - ra);
      sd_q       <= swwt_pkg::DeltaW'(sb - sa);
      now_min0_q <= swwt_pkg::to_minutes(in_item_i.hour, in_item_i.minute);
      sec0_q     <= in_item_i.second;
    end
  end

  // Stages 2 to 4: interpolation, time of day carried alongside
  swwt_pkg::stage_adv_t ctrl;
  logic [MinW-1:0]      rise_min, set_min;

  assign ctrl = '{s2: adv[1], s3: adv[2], s4: adv[3]};

  swwt_interp u_rise (
    .clk_i     (clk_i),
    .adv_i     (ctrl),
    .base_i    (ra_q),
    .delta_i   (rd_q),
    .num_i     (num_q),
    .days_i    (dlen_q),
    .minutes_o (rise_min)
  );

  swwt_interp u_set (
    .clk_i     (clk_i),
    .adv_i     (ctrl),
    .base_i    (sa_q),
    .delta_i   (sd_q),
    .num_i     (num_q),
    .days_i    (dlen_q),
    .minutes_o (set_min)
  );

  logic [MinW-1:0] now_min_q [1:3];
  logic [SecW-1:0] now_sec_q [1:3];
  logic [SecW-1:0] now_sec1;

  assign now_sec1 = SecW'({now_min0_q, 6'b0}) - SecW'({now_min0_q, 2'b0}) + SecW'(sec0_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      now_min_q[1] <= now_min0_q;
      now_sec_q[1] <= now_sec1;
    end
    for (int k = 2; k <= 3; k++) begin
      if (adv[k]) begin
        now_min_q[k] <= now_min_q[k-1];
        now_sec_q[k] <= now_sec_q[k-1];
      end
    end
  end

  // Stage 5: hours, daytime window, sunrise in seconds
  logic [MulW-1:0] rise_hp, set_hp;
  logic [SecW-1:0] target;

  logic [MinW-1:0] rise4_q, set4_q;
  logic [4:0]      rh_q, sh_q;
  logic            day_q, past_q;
  logic [SecW-1:0] tgt_q, now_sec4_q;

  always_comb begin
    rise_hp = MulW'(rise_min) * MulW'(swwt_pkg::Recip60);
    set_hp  = MulW'(set_min) * MulW'(swwt_pkg::Recip60);
    target  = SecW'({rise_min, 6'b0}) - SecW'({rise_min, 2'b0});
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      rise4_q    <= rise_min;
      set4_q     <= set_min;
      rh_q       <= rise_hp[swwt_pkg::RecShift +: 5];
      sh_q       <= set_hp[swwt_pkg::RecShift +: 5];
      day_q      <= (now_min_q[3] >= rise_min) && (now_min_q[3] < set_min);
      past_q     <= now_sec_q[3] >= target;
      tgt_q      <= target;
      now_sec4_q <= now_sec_q[3];
    end
  end

  // Stage 6: minutes and wait, output register
  logic [MinW-1:0]     rise_rem, set_rem;
  logic [SecW:0]       tgt_full, now_ext, wait_full;
  swwt_pkg::out_item_t out_d, out_q;

  always_comb begin
    rise_rem  = rise4_q - (MinW'({rh_q, 6'b0}) - MinW'({rh_q, 2'b0}));
    set_rem   = set4_q - (MinW'({sh_q, 6'b0}) - MinW'({sh_q, 2'b0}));
    // roll over to tomorrow once today's sunrise has passed
    tgt_full  = (SecW + 1)'(tgt_q) + (past_q ? swwt_pkg::SecondsPerDay : '0);
    now_ext   = (SecW + 1)'(now_sec4_q);
    wait_full = (tgt_full > now_ext) ? tgt_full - now_ext : '0;
    out_d.rise_hour          = rh_q;
    out_d.rise_minute        = rise_rem[5:0];
    out_d.set_hour           = sh_q;
    out_d.set_minute         = set_rem[5:0];
    out_d.is_daytime         = day_q;
    out_d.seconds_to_sunrise = wait_full[SecW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_item_o  = out_q;

  `SWWT_ASSERT(a_empty_head_ready, clk_i, rst_ni, !vld_q[0] |-> in_ready_o)
  `SWWT_ASSERT(a_accept_fills_head, clk_i, rst_ni, in_valid_i && in_ready_o |=> vld_q[0])
  `SWWT_ASSERT(a_minute_range, clk_i, rst_ni, out_valid_o |-> (out_item_o.rise_minute < 6'd60) && (out_item_o.set_minute < 6'd60))
  `SWWT_ASSERT_NEVER(a_wait_range, clk_i, rst_ni, out_valid_o && (out_item_o.seconds_to_sunrise > 17'd86400))
  `SWWT_ASSERT_NEVER(a_daytime_wait, clk_i, rst_ni, out_valid_o && out_item_o.is_daytime && (out_item_o.seconds_to_sunrise == '0))

endmodule

@@ hdl/swwt_interp.sv @@
module swwt_interp (
  input  logic                               clk_i,
  input  swwt_pkg::stage_adv_t               adv_i,
  input  logic [swwt_pkg::MinW-1:0]          base_i,
  input  logic signed [swwt_pkg::DeltaW-1:0] delta_i,
  input  logic [swwt_pkg::NumW-1:0]          num_i,
  input  logic [swwt_pkg::NumW-1:0]          days_i,
  output logic [swwt_pkg::MinW-1:0]          minutes_o
);

  localparam int unsigned XExtW = swwt_pkg::XW + 1;
  localparam int unsigned PW    = swwt_pkg::XW + swwt_pkg::RecW;

  // Stage 2: biased numerator 2*delta*n + d + 2*d*RoundBias
  logic signed [swwt_pkg::XW-1:0] dn;
  logic [XExtW-1:0]               x_wide;
  logic [swwt_pkg::XW-1:0]        x_d, x_q;
  logic [swwt_pkg::DivW-1:0]      dd_q;
  logic [swwt_pkg::RecW-1:0]      rec_q;
  logic [swwt_pkg::MinW-1:0]      base2_q;

  always_comb begin
    dn     = swwt_pkg::XW'(delta_i) * swwt_pkg::XW'($signed({1'b0, num_i}));
    x_wide = (XExtW'(dn) << 1) + XExtW'(days_i) * XExtW'(swwt_pkg::DayOffset);
    x_d    = x_wide[swwt_pkg::XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      x_q     <= x_d;
      dd_q    <= {days_i, 1'b0};
      rec_q   <= swwt_pkg::recip_2d(days_i);
      base2_q <= base_i;
    end
  end

  // Stage 3: quotient estimate by reciprocal, at most one low
  logic [PW-1:0]             prod;
  logic [swwt_pkg::QW-1:0]   q0_q;
  logic [swwt_pkg::XW-1:0]   x3_q;
  logic [swwt_pkg::DivW-1:0] dd3_q;
  logic [swwt_pkg::MinW-1:0] base3_q;

  assign prod = PW'(x_q) * PW'(rec_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      q0_q    <= prod[swwt_pkg::RecShift +: swwt_pkg::QW];
      x3_q    <= x_q;
      dd3_q   <= dd_q;
      base3_q <= base2_q;
    end
  end

  // Stage 4: correct the quotient, drop the bias
  logic [swwt_pkg::XW-1:0]   qd, rem;
  logic [swwt_pkg::QW:0]     q;
  logic [swwt_pkg::MinW:0]   res;
  logic [swwt_pkg::MinW-1:0] res_q;

  always_comb begin
    qd  = swwt_pkg::XW'(q0_q) * swwt_pkg::XW'(dd3_q);
    rem = x3_q - qd;
    q   = (swwt_pkg::QW + 1)'(q0_q)
        + (swwt_pkg::QW + 1)'(rem >= swwt_pkg::XW'(dd3_q));
    res = (swwt_pkg::MinW + 1)'(base3_q) + (swwt_pkg::MinW + 1)'(q)
        - (swwt_pkg::MinW + 1)'(swwt_pkg::RoundBias);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      res_q <= res[swwt_pkg::MinW-1:0];
    end
  end

  assign minutes_o = res_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int DaySeconds = 86400;
  localparam int NumRandom  = 1200;
  localparam int IdlePct    = 27;
  localparam int CycleLimit = 200000;

  class sun_scoreboard;
    swwt_pkg::out_item_t pending_times[$];
    int unsigned         failures;

    function new();
      failures = 0;
    endfunction

    // Month-start sunrise in minutes of day; entry 12 is January again.
    static function int rise_at(int idx);
      case (idx)
        1:       return 6 * 60 + 47;
        2:       return 6 * 60 + 40;
        3:       return 6 * 60 + 20;
        4:       return 6 * 60 + 3;
        5:       return 5 * 60 + 54;
        6:       return 5 * 60 + 55;
        7:       return 6 * 60 + 3;
        8:       return 6 * 60 + 7;
        9:       return 6 * 60 + 5;
        10:      return 6 * 60 + 9;
        11:      return 6 * 60 + 22;
        default: return 6 * 60 + 41;
      endcase
    endfunction

    static function int set_at(int idx);
      case (idx)
        1:       return 18 * 60 + 22;
        2:       return 18 * 60 + 28;
        3:       return 18 * 60 + 28;
        4:       return 18 * 60 + 33;
        5:       return 18 * 60 + 42;
        6:       return 18 * 60 + 47;
        7:       return 18 * 60 + 43;
        8:       return 18 * 60 + 25;
        9:       return 18 * 60 + 3;
        10:      return 17 * 60 + 44;
        11:      return 17 * 60 + 41;
        default: return 18 * 60 + 5;
      endcase
    endfunction

    // February is always 28 days.
    static function int days_in_month(int idx);
      case (idx)
        1:             return 28;
        3, 5, 8, 10:   return 30;
        default:       return 31;
      endcase
    endfunction

    // Round half up of a + (b - a) * n / d; the numerator is always positive here.
    static function int blend(int a, int b, int n, int d);
      return (2 * a * d + 2 * (b - a) * n + d) / (2 * d);
    endfunction

    function swwt_pkg::out_item_t sun_times(swwt_pkg::in_item_t it);
      swwt_pkg::out_item_t r;
      int                  cur;
      int                  d;
      int                  n;
      int                  rise;
      int                  set_min;
      int                  now_min;
      int                  now_sec;
      int                  target;
      cur = (it.month >= 1 && it.month <= 12) ? int'(it.month) - 1 : 0;
      d = days_in_month(cur);
      n = int'(it.day) - 1;
      if (n < 0) n = 0;
      if (n > d) n = d;
      rise    = blend(rise_at(cur), rise_at(cur + 1), n, d);
      set_min = blend(set_at(cur), set_at(cur + 1), n, d);
      now_min = int'(it.hour) * 60 + int'(it.minute);
      now_sec = now_min * 60 + int'(it.second);
      target  = rise * 60;
      if (now_sec >= target) target += DaySeconds;
      r.rise_hour          = 5'(rise / 60);
      r.rise_minute        = 6'(rise % 60);
      r.set_hour           = 5'(set_min / 60);
      r.set_minute         = 6'(set_min % 60);
      r.is_daytime         = (now_min >= rise && now_min < set_min);
      r.seconds_to_sunrise = 17'((target > now_sec) ? target - now_sec : 0);
      return r;
    endfunction

    function void note_input(swwt_pkg::in_item_t it);
      pending_times.push_back(sun_times(it));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check(swwt_pkg::out_item_t got);
      swwt_pkg::out_item_t want;
      if (pending_times.size() == 0) begin
        $error("result with no item waiting: %p", got);
        failures++;
        return;
      end
      want = pending_times.pop_front();
      compare_field("rise_hour", want.rise_hour, got.rise_hour);
      compare_field("rise_minute", want.rise_minute, got.rise_minute);
      compare_field("set_hour", want.set_hour, got.set_hour);
      compare_field("set_minute", want.set_minute, got.set_minute);
      compare_field("is_daytime", want.is_daytime, got.is_daytime);
      compare_field("seconds_to_sunrise", want.seconds_to_sunrise,
                    got.seconds_to_sunrise);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  swwt_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swwt_pkg::out_item_t out_item;

  sun_scoreboard sb;
  int unsigned   items_sent = 0;
  int unsigned   cycles = 0;

  sunrise_window_wake_timer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: check every accepted item, stall at random outside the calm window.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check(out_item);
      out_ready <= (items_sent >= 900 && items_sent < 1100) ||
                   ($urandom_range(99) >= IdlePct);
    end
  end

  function automatic swwt_pkg::in_item_t mk(int mo, int dy, int hr, int mi, int se);
    swwt_pkg::in_item_t q;
    q.month  = 4'(mo);
    q.day    = 5'(dy);
    q.hour   = 5'(hr);
    q.minute = 6'(mi);
    q.second = 6'(se);
    return q;
  endfunction

  // Present one query and hold it until the block takes it.
  task automatic send_query(swwt_pkg::in_item_t q, bit calm);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(q);
    items_sent++;
  endtask

  initial begin
    swwt_pkg::in_item_t queries[$];
    swwt_pkg::in_item_t q;
    int                 pick;
    int                 mod;
    int                 k;
    sb = new();

    queries.push_back(mk(0, 0, 0, 0, 0));       // month zero, day zero, all low
    queries.push_back(mk(15, 31, 31, 63, 63));  // all high: wait saturates to zero
    queries.push_back(mk(13, 15, 12, 30, 30));
    queries.push_back(mk(14, 1, 6, 41, 0));
    queries.push_back(mk(1, 1, 6, 41, 0));      // exactly at sunrise
    queries.push_back(mk(1, 1, 6, 40, 59));
    queries.push_back(mk(1, 1, 18, 5, 0));      // exactly at sunset
    queries.push_back(mk(1, 1, 18, 4, 59));
    queries.push_back(mk(2, 29, 12, 0, 0));     // past the end of February
    queries.push_back(mk(2, 31, 3, 15, 7));
    queries.push_back(mk(4, 31, 20, 10, 5));    // fraction exactly one
    queries.push_back(mk(12, 31, 23, 59, 59));  // blends toward January again
    queries.push_back(mk(6, 1, 24, 0, 0));      // hour above the day
    queries.push_back(mk(7, 16, 5, 63, 63));    // minute and second out of range
    queries.push_back(mk(3, 16, 9, 0, 0));
    queries.push_back(mk(5, 1, 4, 0, 0));
    queries.push_back(mk(8, 15, 6, 3, 0));
    queries.push_back(mk(9, 30, 18, 25, 0));
    queries.push_back(mk(10, 2, 17, 50, 30));
    queries.push_back(mk(11, 20, 0, 0, 1));

    // Mostly proper dates and times, many near the sunrise and sunset edges.
    for (k = 0; k < NumRandom; k++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        q.month = 4'($urandom_range(12, 1));
        q.day   = 5'($urandom_range(sun_scoreboard::days_in_month(int'(q.month) - 1), 1));
        if (pick < 55) mod = $urandom_range(1439);
        else if (pick < 68) mod = $urandom_range(420, 340);
        else mod = $urandom_range(1140, 1050);
        q.hour   = 5'(mod / 60);
        q.minute = 6'(mod % 60);
        q.second = 6'($urandom_range(59));
      end else begin
        q = swwt_pkg::in_item_t'($bits(swwt_pkg::in_item_t)'($urandom));
      end
      queries.push_back(q);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < queries.size(); k++) send_query(queries[k], k >= 500 && k < 800);
    in_valid <= 1'b0;

    while (sb.pending_times.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

@@ sunrise_window_wake_timer_top.f @@
+incdir+hdl
hdl/swwt_pkg.sv
hdl/swwt_interp.sv
hdl/sunrise_window_wake_timer_top.sv
tb/tb_top.sv
